// ----- hw/rtl/urr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urr_pkg
// Shared types, register codes and helpers for the round-robin echo ranger.
// ----------------------------------------------------------------------------
package urr_pkg;

    localparam int SENSORS     = 4;
    localparam int RANGE_W     = 12;
    localparam int CM_W        = 11;
    localparam int WIDTH_W     = 16;
    localparam int INTERVAL_W  = 20;
    localparam int SETTLE_W    = 10;
    localparam int TRIGGER_W   = 8;
    localparam int TIMEOUT_W   = 16;
    localparam int SCALE_SHIFT = 26;
    localparam int PROD_W      = 37;

    // ceil(17 * 2^26 / 1000): exact floor(w * 17 / 1000) for all 16-bit w
    localparam logic [20:0] SCALE_MULT = 21'd1140851;

    localparam logic [RANGE_W-1:0]    NO_ECHO      = 12'hFFF;
    localparam logic [INTERVAL_W-1:0] INTERVAL_MAX = 20'hFFFFF;

    typedef enum logic [1:0] {
        CFG_INTERVAL = 2'd0,
        CFG_SETTLE   = 2'd1,
        CFG_TRIGGER  = 2'd2,
        CFG_TIMEOUT  = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_SETTLE  = 3'd1,
        PH_TRIGGER = 3'd2,
        PH_WAIT    = 3'd3,
        PH_MEASURE = 3'd4
    } phase_t;

    typedef struct packed {
        logic [INTERVAL_W-1:0] interval_us;
        logic [SETTLE_W-1:0]   settle_us;
        logic [TRIGGER_W-1:0]  trigger_us;
        logic [TIMEOUT_W-1:0]  timeout_us;
    } urr_cfg_t;

    // turn -> sensor bit: front, left, back, right
    function automatic logic [1:0] sensor_of_turn(input logic [1:0] turn);
        logic [1:0] s;
        unique case (turn)
            2'd0:    s = 2'd0;
            2'd1:    s = 2'd2;
            2'd2:    s = 2'd1;
            default: s = 2'd3;
        endcase
        return s;
    endfunction

    function automatic logic [CM_W-1:0] cm_of_width(input logic [WIDTH_W-1:0] w);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(w) * PROD_W'(SCALE_MULT);
        return prod[SCALE_SHIFT +: CM_W];
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/ultrasonic_round_robin_ranger.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ultrasonic_round_robin_ranger
// Four-sensor echo ranger stepped once per microsecond tick word.
//
// Channel   Dir  Contents
// s_*       in   tdata[3:0] echo_levels, one word per tick
// m_*       out  tdata trigger lines and four ranges, tuser fresh flags
// cfg_*     in   write port for interval, settle, trigger, timeout
//
// One word per cycle while m_tready is high; m_* valid follows s_* accept via
// the input register, then sequencer and cm scaling into the result register.
// Reset: ranges read -1, sequencer idle, front sensor first.
// A stall on m_tready holds the result and backs up into s_tready.
// ----------------------------------------------------------------------------
module ultrasonic_round_robin_ranger
    import urr_pkg::*;
#(
    parameter int SENSOR_COUNT = 4
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [3:0] echo_levels
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [55:0]                m_tdata,   // trigger_lines, range_front,
                                                  // range_back, range_left,
                                                  // range_right, zero pad
    output logic [2:0]                 m_tuser,   // fresh, fresh_sensor
    input  wire logic                  cfg_we,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [INTERVAL_W-1:0] cfg_data
);

    localparam int ROT_LEN = (SENSOR_COUNT < 1) ? 1 :
                             ((SENSOR_COUNT > 4) ? 4 : SENSOR_COUNT);

    urr_cfg_t           cfg;
    logic               in_valid;
    logic [SENSORS-1:0] in_echo;
    logic               in_take;
    logic [SENSORS-1:0] trigger_lines;
    logic [RANGE_W-1:0] range_front;
    logic [RANGE_W-1:0] range_back;
    logic [RANGE_W-1:0] range_left;
    logic [RANGE_W-1:0] range_right;
    logic               fresh;
    logic [1:0]         fresh_sensor;

    urr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    urr_ingress u_ingress (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_echo   (s_tdata[SENSORS-1:0]),
        .in_valid (in_valid),
        .in_echo  (in_echo),
        .in_take  (in_take)
    );

    urr_core #(
        .ROT_LEN (ROT_LEN)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_valid      (in_valid),
        .in_echo       (in_echo),
        .in_take       (in_take),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .trigger_lines (trigger_lines),
        .range_front   (range_front),
        .range_back    (range_back),
        .range_left    (range_left),
        .range_right   (range_right),
        .fresh         (fresh),
        .fresh_sensor  (fresh_sensor)
    );

    assign m_tdata = {4'b0000, range_right, range_left, range_back, range_front,
                      trigger_lines};
    assign m_tuser = {fresh_sensor, fresh};

endmodule
`default_nettype wire

// ----- hw/rtl/urr_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urr_cfg
// Timing registers for the ranger, written through a plain write port.
// ----------------------------------------------------------------------------
module urr_cfg
    import urr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [INTERVAL_W-1:0] cfg_data,
    output urr_cfg_t                   cfg
);

    urr_cfg_t cfg_reg;
    urr_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_INTERVAL: cfg_next.interval_us = cfg_data;
                CFG_SETTLE:   cfg_next.settle_us   = cfg_data[SETTLE_W-1:0];
                CFG_TRIGGER:  cfg_next.trigger_us  = cfg_data[TRIGGER_W-1:0];
                CFG_TIMEOUT:  cfg_next.timeout_us  = cfg_data[TIMEOUT_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.interval_us <= 20'd51000;
            cfg_reg.settle_us   <= 10'd102;
            cfg_reg.trigger_us  <= 8'd10;
            cfg_reg.timeout_us  <= 16'd30000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/urr_ingress.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urr_ingress
// Input register for the echo sample word.
// ----------------------------------------------------------------------------
module urr_ingress
    import urr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [SENSORS-1:0] s_echo,
    output logic                    in_valid,
    output logic [SENSORS-1:0]      in_echo,
    input  wire logic               in_take
);

    logic               valid_reg;
    logic               valid_next;
    logic [SENSORS-1:0] echo_reg;
    logic               load;

    assign s_tready = !valid_reg || in_take;
    assign load     = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (in_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            echo_reg <= s_echo;
        end
    end

    assign in_valid = valid_reg;
    assign in_echo  = echo_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/urr_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urr_core
// Measurement sequencer, distance scaling and result register.
// ----------------------------------------------------------------------------
module urr_core
    import urr_pkg::*;
#(
    parameter int ROT_LEN = 4
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire urr_cfg_t           cfg,
    input  wire logic               in_valid,
    input  wire logic [SENSORS-1:0] in_echo,
    output logic                    in_take,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [SENSORS-1:0]      trigger_lines,
    output logic [RANGE_W-1:0]      range_front,
    output logic [RANGE_W-1:0]      range_back,
    output logic [RANGE_W-1:0]      range_left,
    output logic [RANGE_W-1:0]      range_right,
    output logic                    fresh,
    output logic [1:0]              fresh_sensor
);

    localparam logic [1:0] LAST_TURN = 2'(ROT_LEN - 1);

    phase_t                phase_reg,          phase_next;
    logic [1:0]            turn_reg,           turn_next;
    logic [INTERVAL_W-1:0] interval_count_reg, interval_count_next;
    logic [TIMEOUT_W-1:0]  phase_count_reg,    phase_count_next;
    logic [WIDTH_W-1:0]    echo_width_reg,     echo_width_next;
    logic [RANGE_W-1:0]    ranges_reg [SENSORS];
    logic [RANGE_W-1:0]    ranges_next [SENSORS];
    logic [SENSORS-1:0]    trig_reg,           trig_next;
    logic                  fresh_reg,          fresh_next;
    logic [1:0]            fresh_sensor_reg,   fresh_sensor_next;
    logic                  valid_reg,          valid_next;

    logic [1:0]            sensor;
    logic                  echo_high;
    logic [RANGE_W-1:0]    cm_code;
    logic                  store;
    logic [RANGE_W-1:0]    store_code;

    assign in_take   = in_valid && (!valid_reg || m_tready);
    assign sensor    = sensor_of_turn(turn_reg);
    assign echo_high = in_echo[sensor];
    assign cm_code   = {1'b0, cm_of_width(echo_width_reg)};

    always_comb
    begin
        interval_count_next = interval_count_reg;
        phase_next          = phase_reg;
        phase_count_next    = phase_count_reg;
        echo_width_next     = echo_width_reg;
        trig_next           = '0;
        store               = 1'b0;
        store_code          = NO_ECHO;

        if (interval_count_next != INTERVAL_MAX)
        begin
            interval_count_next = interval_count_next + 1'b1;
        end

        if (phase_next == PH_IDLE && interval_count_next >= cfg.interval_us)
        begin
            interval_count_next = '0;
            phase_next          = PH_SETTLE;
            phase_count_next    = '0;
            echo_width_next     = '0;
        end

        if (phase_next == PH_SETTLE)
        begin
            if (phase_count_next >= TIMEOUT_W'(cfg.settle_us))
            begin
                phase_next       = PH_TRIGGER;
                phase_count_next = '0;
            end
            else
            begin
                phase_count_next = phase_count_next + 1'b1;
            end
        end

        if (phase_next == PH_TRIGGER)
        begin
            if (phase_count_next >= TIMEOUT_W'(cfg.trigger_us))
            begin
                phase_next       = PH_WAIT;
                phase_count_next = '0;
            end
            else
            begin
                phase_count_next = phase_count_next + 1'b1;
                trig_next        = SENSORS'(1) << sensor;
            end
        end

        if (phase_next == PH_WAIT)
        begin
            if (phase_count_next >= cfg.timeout_us)
            begin
                store = 1'b1;
            end
            else
            begin
                phase_count_next = phase_count_next + 1'b1;
                if (echo_high)
                begin
                    echo_width_next = WIDTH_W'(1);
                    phase_next      = PH_MEASURE;
                end
            end
        end
        else if (phase_next == PH_MEASURE)
        begin
            if (phase_count_next >= cfg.timeout_us)
            begin
                store = 1'b1;
            end
            else
            begin
                phase_count_next = phase_count_next + 1'b1;
                if (echo_high)
                begin
                    echo_width_next = echo_width_next + 1'b1;
                end
                else
                begin
                    store      = 1'b1;
                    store_code = cm_code;
                end
            end
        end

        if (store)
        begin
            phase_next       = PH_IDLE;
            phase_count_next = '0;
        end
    end

    always_comb
    begin
        turn_next         = turn_reg;
        fresh_next        = store;
        fresh_sensor_next = '0;
        for (int i = 0; i < SENSORS; i++)
        begin
            ranges_next[i] = ranges_reg[i];
        end
        if (store)
        begin
            ranges_next[sensor] = store_code;
            fresh_sensor_next   = sensor;
            turn_next           = (turn_reg == LAST_TURN) ? 2'd0 : turn_reg + 2'd1;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (in_take)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg          <= 1'b0;
            phase_reg          <= PH_IDLE;
            turn_reg           <= 2'd0;
            interval_count_reg <= '0;
            phase_count_reg    <= '0;
            echo_width_reg     <= '0;
            trig_reg           <= '0;
            fresh_reg          <= 1'b0;
            fresh_sensor_reg   <= '0;
            for (int i = 0; i < SENSORS; i++)
            begin
                ranges_reg[i] <= NO_ECHO;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            if (in_take)
            begin
                phase_reg          <= phase_next;
                turn_reg           <= turn_next;
                interval_count_reg <= interval_count_next;
                phase_count_reg    <= phase_count_next;
                echo_width_reg     <= echo_width_next;
                trig_reg           <= trig_next;
                fresh_reg          <= fresh_next;
                fresh_sensor_reg   <= fresh_sensor_next;
                for (int i = 0; i < SENSORS; i++)
                begin
                    ranges_reg[i] <= ranges_next[i];
                end
            end
        end
    end

    assign m_tvalid      = valid_reg;
    assign trigger_lines = trig_reg;
    assign range_front   = ranges_reg[0];
    assign range_back    = ranges_reg[1];
    assign range_left    = ranges_reg[2];
    assign range_right   = ranges_reg[3];
    assign fresh         = fresh_reg;
    assign fresh_sensor  = fresh_sensor_reg;

    a_fresh_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg |-> phase_reg == PH_IDLE)
        else $error("store left the sequencer outside idle");

    a_one_trigger: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(trig_reg))
        else $error("more than one trigger line driven");

    a_trigger_phase: assert property (@(posedge clk) disable iff (!rst_n)
        trig_reg != '0 |-> phase_reg == PH_TRIGGER)
        else $error("trigger driven outside trigger phase");

    a_width_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_MEASURE |-> echo_width_reg != '0 && echo_width_reg <= phase_count_reg)
        else $error("echo width out of step with phase count");

endmodule
`default_nettype wire
